@@ hw/rtl/gprcd_pkg.sv @@
// Shared types, constants and the button table of the gamepad report change detector.
`default_nettype none
package gprcd_pkg;

    // Number of controller slots by default.
    localparam int SLOT_COUNT_DEF = 4;
    // Axes per slot and table buttons per report.
    localparam int AXES    = 6;
    localparam int BUTTONS = 14;
    // One pending bit for the connection event, then buttons, then axes.
    localparam int PEND_W  = 1 + BUTTONS + AXES;
    localparam int BTN_BASE  = 1;
    localparam int AXIS_BASE = 1 + BUTTONS;

    // Stream and configuration widths.
    localparam int IN_TDATA_W  = 104;
    localparam int OUT_TDATA_W = 40;
    localparam int KIND_W      = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 15;

    // Register reset values.
    localparam logic [7:0]  TRIG_THR_RST = 8'd30;
    localparam logic [14:0] LDZ_RST      = 15'd7849;
    localparam logic [14:0] RDZ_RST      = 15'd8689;
    localparam logic [14:0] MOVE_THR_RST = 15'd65;
    localparam logic [14:0] FULL_SCALE   = 15'h7FFF;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TRIG_THR = 2'd0,
        REG_LDZ      = 2'd1,
        REG_RDZ      = 2'd2,
        REG_MOVE_THR = 2'd3
    } cfg_reg_t;

    // Event kinds.
    typedef enum logic [KIND_W-1:0] {
        EV_CONNECT    = 3'd0,
        EV_DISCONNECT = 3'd1,
        EV_BTN_DOWN   = 3'd2,
        EV_BTN_UP     = 3'd3,
        EV_AXIS       = 3'd4
    } event_kind_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_MERGE,
        ST_EMIT
    } seq_state_t;

    // Bit of the raw button word for each table position.
    function automatic logic [15:0] btn_mask(input logic [3:0] pos);
        logic [15:0] m;
        unique case (pos)
            4'd0:    m = 16'h1000;
            4'd1:    m = 16'h2000;
            4'd2:    m = 16'h4000;
            4'd3:    m = 16'h8000;
            4'd4:    m = 16'h0100;
            4'd5:    m = 16'h0200;
            4'd6:    m = 16'h0010;
            4'd7:    m = 16'h0020;
            4'd8:    m = 16'h0040;
            4'd9:    m = 16'h0080;
            4'd10:   m = 16'h0001;
            4'd11:   m = 16'h0002;
            4'd12:   m = 16'h0004;
            4'd13:   m = 16'h0008;
            default: m = 16'h0000;
        endcase
        return m;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/gprcd_norm_lane.sv @@
// One normalization lane: deadzone test and bit-serial scaling of a magnitude to Q0.15.
`default_nettype none
module gprcd_norm_lane (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [15:0] mag,
    input  wire logic [14:0] dz,
    input  wire logic [15:0] den,
    output logic             busy,
    output logic [14:0]      q
);
    import gprcd_pkg::*;

    logic [15:0] rem_reg, rem_next;
    logic [14:0] q_reg, q_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [15:0] diff;
    logic [16:0] shifted;

    assign diff    = mag - {1'b0, dz};
    assign shifted = {rem_reg, 1'b0};

    // Restoring division of diff * 2^15 by den, one quotient bit a cycle.
    always_comb
    begin
        rem_next  = rem_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            q_next   = '0;
            rem_next = diff;
            cnt_next = 4'd15;
            if (mag <= {1'b0, dz})
            begin
                busy_next = 1'b0;
            end
            else if (diff >= den)
            begin
                // Full scale or beyond saturates.
                q_next    = FULL_SCALE;
                busy_next = 1'b0;
            end
            else
            begin
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, den})
            begin
                rem_next = 16'(shifted - {1'b0, den});
                q_next   = {q_reg[13:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[15:0];
                q_next   = {q_reg[13:0], 1'b0};
            end
            cnt_next = cnt_reg - 4'd1;
            if (cnt_reg == 4'd1)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign busy = busy_reg;
    assign q    = q_reg;

endmodule
`default_nettype wire

@@ hw/rtl/gamepad_report_change_detector.sv @@
// Top level: slot state, six normalization lanes, event merge and serial event output.
// Sequence: the lanes divide after accept, the merge runs once all lanes are done, and the
// events then transfer one per cycle while m_tready is high.
// A new report is taken only in idle, after the last event of the previous one has gone out.
// Reset (rst_n low, asynchronous): all slots disconnected, buttons and axes zero,
// registers at their defaults, no transfer pending.
`default_nettype none
module gamepad_report_change_detector #(
    parameter int SLOT_COUNT = gprcd_pkg::SLOT_COUNT_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // slot[1:0], present[2], button_word[18:3], left_trigger[26:19],
    // right_trigger[34:27], left_x[50:35], left_y[66:51], right_x[82:67], right_y[98:83]
    input  wire logic [gprcd_pkg::IN_TDATA_W-1:0]   s_tdata,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // event_slot[1:0], control_index[5:2], raw_value[21:6], norm_value[37:22]
    output logic [gprcd_pkg::OUT_TDATA_W-1:0]       m_tdata,
    // event_kind[2:0]
    output logic [gprcd_pkg::KIND_W-1:0]            m_tuser,
    output logic                                    m_tlast,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    input  wire logic                               cfg_we,
    input  wire logic [gprcd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [gprcd_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import gprcd_pkg::*;

    localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    // Configuration registers.
    logic [7:0]  trig_thr_reg;
    logic [14:0] ldz_reg, rdz_reg, move_thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trig_thr_reg <= TRIG_THR_RST;
            ldz_reg      <= LDZ_RST;
            rdz_reg      <= RDZ_RST;
            move_thr_reg <= MOVE_THR_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_TRIG_THR: trig_thr_reg <= cfg_data[7:0];
                REG_LDZ:      ldz_reg      <= cfg_data;
                REG_RDZ:      rdz_reg      <= cfg_data;
                REG_MOVE_THR: move_thr_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    // Input field unpacking.
    logic [1:0]  in_slot;
    logic        in_present;
    logic [15:0] in_buttons;
    logic [15:0] in_raw [AXES];

    assign in_slot    = s_tdata[1:0];
    assign in_present = s_tdata[2];
    assign in_buttons = s_tdata[18:3];
    assign in_raw[0]  = {8'd0, s_tdata[26:19]};
    assign in_raw[1]  = {8'd0, s_tdata[34:27]};
    assign in_raw[2]  = s_tdata[50:35];
    assign in_raw[3]  = s_tdata[66:51];
    assign in_raw[4]  = s_tdata[82:67];
    assign in_raw[5]  = s_tdata[98:83];

    // Sequencer state and the latched report.
    seq_state_t state_reg, state_next;
    logic [1:0]  slot_reg;
    logic        present_reg;
    logic [15:0] buttons_reg;
    logic [15:0] raw_reg [AXES];
    logic [PEND_W-1:0] pend_reg, pend_next;
    logic        accept;

    assign accept = s_tvalid && s_tready;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            slot_reg    <= in_slot;
            present_reg <= in_present;
            buttons_reg <= in_buttons;
            for (int a = 0; a < AXES; a++)
            begin
                raw_reg[a] <= in_raw[a];
            end
        end
    end

    // Lane operands: triggers use the threshold, sticks their deadzone.
    logic [15:0] lane_mag [AXES];
    logic [14:0] lane_dz  [AXES];
    logic [15:0] lane_den [AXES];
    logic        lane_busy [AXES];
    logic [14:0] lane_q   [AXES];

    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            if (a < 2)
            begin
                lane_mag[a] = in_raw[a];
                lane_dz[a]  = {7'd0, trig_thr_reg};
                lane_den[a] = {8'd0, 8'd255 - trig_thr_reg};
            end
            else
            begin
                lane_mag[a] = in_raw[a][15] ? 16'(-in_raw[a]) : in_raw[a];
                lane_dz[a]  = (a < 4) ? ldz_reg : rdz_reg;
                lane_den[a] = {1'b0, FULL_SCALE - lane_dz[a]};
            end
        end
    end

    // Six lanes work on the axes of one report side by side.
    for (genvar g = 0; g < AXES; g++)
    begin : g_lane
        gprcd_norm_lane u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .start (accept),
            .mag   (lane_mag[g]),
            .dz    (lane_dz[g]),
            .den   (lane_den[g]),
            .busy  (lane_busy[g]),
            .q     (lane_q[g])
        );
    end

    // Signed normalized values; Y axes are negated.
    logic [15:0] nv [AXES];
    logic        lanes_busy;

    always_comb
    begin
        lanes_busy = 1'b0;
        for (int a = 0; a < AXES; a++)
        begin
            lanes_busy = lanes_busy | lane_busy[a];
            if ((a >= 2) && (raw_reg[a][15] ^ (a == 3 || a == 5)))
            begin
                nv[a] = 16'(-{1'b0, lane_q[a]});
            end
            else
            begin
                nv[a] = {1'b0, lane_q[a]};
            end
        end
    end

    // Per-slot state.
    logic              conn_reg [SLOT_COUNT];
    logic [15:0]       btn_reg  [SLOT_COUNT];
    logic [15:0]       axis_reg [SLOT_COUNT][AXES];
    logic [SLOT_IDX_W-1:0] sidx;
    logic              slot_ok;

    assign sidx    = SLOT_IDX_W'(slot_reg);
    assign slot_ok = 32'(slot_reg) < SLOT_COUNT;

    // Merge: compare the report with the slot state and build the pending event set.
    logic        chg;
    logic [15:0] base_btn;
    logic [15:0] base_axis [AXES];
    logic [PEND_W-1:0] merge_set;
    logic [16:0] dlt [AXES];
    logic [16:0] dabs [AXES];

    always_comb
    begin
        chg      = slot_ok && (present_reg != conn_reg[sidx]);
        base_btn = chg ? 16'd0 : btn_reg[sidx];
        merge_set = '0;
        merge_set[0] = chg;
        for (int a = 0; a < AXES; a++)
        begin
            base_axis[a] = chg ? 16'd0 : axis_reg[sidx][a];
            dlt[a]  = {nv[a][15], nv[a]} - {base_axis[a][15], base_axis[a]};
            dabs[a] = dlt[a][16] ? 17'(-dlt[a]) : dlt[a];
            merge_set[AXIS_BASE + a] = slot_ok && present_reg
                                       && (dabs[a] > {2'd0, move_thr_reg});
        end
        for (int b = 0; b < BUTTONS; b++)
        begin
            merge_set[BTN_BASE + b] = slot_ok && present_reg
                && (((buttons_reg ^ base_btn) & btn_mask(4'(b))) != 16'd0);
        end
    end

    // Slot state update at the merge cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < SLOT_COUNT; s++)
            begin
                conn_reg[s] <= 1'b0;
                btn_reg[s]  <= '0;
                for (int a = 0; a < AXES; a++)
                begin
                    axis_reg[s][a] <= '0;
                end
            end
        end
        else if ((state_reg == ST_MERGE) && slot_ok)
        begin
            conn_reg[sidx] <= present_reg;
            btn_reg[sidx]  <= present_reg ? buttons_reg : base_btn;
            for (int a = 0; a < AXES; a++)
            begin
                axis_reg[sidx][a] <= merge_set[AXIS_BASE + a] ? nv[a] : base_axis[a];
            end
        end
    end

    // Event selection: the lowest pending bit goes out first.
    logic [PEND_W-1:0] low_bit, pend_rest;
    logic [4:0]        sel;
    event_kind_t       ev_kind;
    logic [3:0]        ev_idx;
    logic [15:0]       ev_raw, ev_norm;

    assign low_bit   = pend_reg & (~pend_reg + PEND_W'(1));
    assign pend_rest = pend_reg & ~low_bit;

    always_comb
    begin
        sel = '0;
        for (int i = PEND_W - 1; i >= 0; i--)
        begin
            if (pend_reg[i])
            begin
                sel = 5'(i);
            end
        end
        ev_idx  = '0;
        ev_raw  = '0;
        ev_norm = '0;
        if (sel == 5'd0)
        begin
            ev_kind = present_reg ? EV_CONNECT : EV_DISCONNECT;
        end
        else if (sel < 5'(AXIS_BASE))
        begin
            ev_idx = 4'(sel - 5'(BTN_BASE));
            if ((buttons_reg & btn_mask(ev_idx)) != 16'd0)
            begin
                ev_kind = EV_BTN_DOWN;
                ev_raw  = 16'd1;
                ev_norm = {1'b0, FULL_SCALE};
            end
            else
            begin
                ev_kind = EV_BTN_UP;
            end
        end
        else
        begin
            ev_kind = EV_AXIS;
            ev_idx  = 4'(sel - 5'(AXIS_BASE));
            ev_raw  = raw_reg[3'(ev_idx)];
            ev_norm = nv[3'(ev_idx)];
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_tvalid) state_next = ST_DIV;
            ST_DIV:   if (!lanes_busy) state_next = ST_MERGE;
            ST_MERGE: state_next = (merge_set != '0) ? ST_EMIT : ST_IDLE;
            ST_EMIT:  if (m_tready && (pend_rest == '0)) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Pending set update.
    always_comb
    begin
        pend_next = pend_reg;
        unique case (state_reg)
            ST_MERGE: pend_next = merge_set;
            ST_EMIT:  if (m_tready) pend_next = pend_rest;
            default:  pend_next = pend_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pend_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
        end
    end

    // Handshake outputs.
    always_comb
    begin
        s_tready = (state_reg == ST_IDLE);
        m_tvalid = (state_reg == ST_EMIT);
        m_tlast  = (pend_rest == '0);
        m_tuser  = ev_kind;
        m_tdata  = {2'd0, ev_norm, ev_raw, ev_idx, slot_reg};
    end

endmodule
`default_nettype wire
